// ===== hw/rtl/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// Types and constants shared by the stereo mixer modules.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int unsigned BLK_PER_VOICE = 6;
  localparam int unsigned SAMPLE_W      = 24;
  localparam int unsigned STATE_W       = 32;
  localparam int unsigned GAIN_W        = 18;
  localparam int unsigned OUT_W         = 23;
  localparam int unsigned VOICE_W       = 4;
  localparam int unsigned ACC_W         = 53;
  localparam int unsigned L24_W         = 39;
  localparam int unsigned HSUM_W        = 40;
  localparam int unsigned POST_W        = 59;

  // 0.9995 in Q0.30
  localparam logic signed [30:0] DC_COEF = 31'sd1073204953;
  // 11 V in Q4.18
  localparam logic signed [OUT_W-1:0] OUT_LIMIT = 23'sd2883584;

  typedef enum logic [2:0] {
    REG_CH1_L = 3'd0,
    REG_CH1_R = 3'd1,
    REG_CH2_L = 3'd2,
    REG_CH2_R = 3'd3,
    REG_CH3   = 3'd4,
    REG_CH4   = 3'd5,
    REG_HP    = 3'd6,
    REG_MAIN  = 3'd7
  } reg_idx_t;

  // DC blocker slot within a voice
  typedef enum logic [2:0] {
    BLK_CH1  = 3'd0,
    BLK_CH2  = 3'd1,
    BLK_CH3L = 3'd2,
    BLK_CH3R = 3'd3,
    BLK_CH4L = 3'd4,
    BLK_CH4R = 3'd5
  } blk_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_Y,
    ST_ACC,
    ST_RND,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic [GAIN_W-1:0] ch1_l;
    logic [GAIN_W-1:0] ch1_r;
    logic [GAIN_W-1:0] ch2_l;
    logic [GAIN_W-1:0] ch2_r;
    logic [GAIN_W-1:0] ch3;
    logic [GAIN_W-1:0] ch4;
    logic [GAIN_W-1:0] hp;
    logic [GAIN_W-1:0] main;
  } gains_t;

  typedef struct packed {
    logic                       voice_ok;
    logic [VOICE_W-1:0]         voice;
    logic signed [SAMPLE_W-1:0] ch1;
    logic signed [SAMPLE_W-1:0] ch2;
    logic signed [SAMPLE_W-1:0] ch3_l;
    logic signed [SAMPLE_W-1:0] ch3_r;
    logic signed [SAMPLE_W-1:0] ch4_l;
    logic signed [SAMPLE_W-1:0] ch4_r;
    logic                       ch3_r_present;
    logic                       ch4_r_present;
  } item_t;

  typedef struct packed {
    logic [VOICE_W-1:0]      voice;
    logic signed [OUT_W-1:0] main_left;
    logic signed [OUT_W-1:0] main_right;
    logic signed [OUT_W-1:0] headphone;
  } res_t;

endpackage

// ===== hw/rtl/psm_queue.sv =====
// ----------------------------------------------------------------------------
// psm_queue
// Two-entry request queue between the front and the back of the mixer.
// ----------------------------------------------------------------------------
module psm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  psm_pkg::item_t  push_data,
  output logic            full,
  input  logic            pop,
  output psm_pkg::item_t  pop_data,
  output logic            empty
);
  import psm_pkg::*;

  item_t      mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/psm_front.sv =====
// ----------------------------------------------------------------------------
// psm_front
// Accepts input requests, unpacks them and flags voices out of range.
// ----------------------------------------------------------------------------
module psm_front #(
  parameter int unsigned NUM_VOICES = 16
) (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [151:0]    in_tdata,
  input  logic [1:0]      in_tuser,
  input  logic            q_full,
  output logic            q_push,
  output psm_pkg::item_t  q_data
);
  import psm_pkg::*;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_data.voice         = in_tdata[3:0];
    q_data.ch1           = in_tdata[27:4];
    q_data.ch2           = in_tdata[51:28];
    q_data.ch3_l         = in_tdata[75:52];
    q_data.ch3_r         = in_tdata[99:76];
    q_data.ch4_l         = in_tdata[123:100];
    q_data.ch4_r         = in_tdata[147:124];
    q_data.ch3_r_present = in_tuser[0];
    q_data.ch4_r_present = in_tuser[1];
    q_data.voice_ok      = ({1'b0, in_tdata[3:0]} < 5'(NUM_VOICES));
  end

endmodule

// ===== hw/rtl/psm_back.sv =====
// ----------------------------------------------------------------------------
// psm_back
// Runs the DC blockers of one voice in turn, mixes and scales the result.
// ----------------------------------------------------------------------------
module psm_back #(
  parameter int unsigned NUM_VOICES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  psm_pkg::gains_t gains,
  input  logic            q_empty,
  input  psm_pkg::item_t  q_data,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output psm_pkg::res_t   res
);
  import psm_pkg::*;

  localparam int unsigned DEPTH  = NUM_VOICES * BLK_PER_VOICE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  st_t st_r, st_nxt;
  item_t cur_r;
  blk_t  k_r;
  logic  mem_we;
  logic  last_blk;
  blk_t  k_nxt;

  logic signed [SAMPLE_W-1:0] mem_x [DEPTH];
  logic signed [STATE_W-1:0]  mem_y [DEPTH];
  logic [DEPTH-1:0]           vld_r;

  logic [6:0]        addr_full;
  logic [ADDR_W-1:0] addr;

  logic signed [SAMPLE_W-1:0] x1_r;
  logic signed [STATE_W-1:0]  y1_r;
  logic                       hit_r;
  logic signed [SAMPLE_W-1:0] x1_eff;
  logic signed [STATE_W-1:0]  y1_eff;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [SAMPLE_W:0]   xd_r;
  logic signed [62:0]         prod_r;
  logic signed [63:0]         prod_rnd;
  logic signed [34:0]         y_sum;
  logic signed [STATE_W-1:0]  y_sat;
  logic signed [STATE_W-1:0]  y_r;

  logic [GAIN_W-1:0]       g_l, g_r;
  logic                    add_l, add_r;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;
  logic signed [ACC_W:0]   acc_l_rnd, acc_r_rnd;
  logic signed [L24_W-1:0] l24_r, r24_r;
  logic signed [HSUM_W-1:0] hsum;

  logic signed [HSUM_W-1:0] m_a;
  logic [GAIN_W-1:0]        m_g;
  logic signed [POST_W-1:0] p_r;
  logic signed [POST_W:0]   p_rnd;
  logic signed [37:0]       p_sh;
  logic signed [OUT_W-1:0]  p_sat;

  logic signed [OUT_W-1:0] ml_r, mr_r, hp_r;

  assign addr_full = {3'b000, cur_r.voice} * 7'd6 + {4'b0000, k_r};
  assign addr      = addr_full[ADDR_W-1:0];

  // Next blocker; a missing right input skips its blocker
  always_comb begin
    last_blk = 1'b0;
    k_nxt    = k_r;
    unique case (k_r)
      BLK_CH1:  k_nxt = BLK_CH2;
      BLK_CH2:  k_nxt = BLK_CH3L;
      BLK_CH3L: k_nxt = cur_r.ch3_r_present ? BLK_CH3R : BLK_CH4L;
      BLK_CH3R: k_nxt = BLK_CH4L;
      BLK_CH4L: begin
        k_nxt    = BLK_CH4R;
        last_blk = !cur_r.ch4_r_present;
      end
      BLK_CH4R: last_blk = 1'b1;
      default:  last_blk = 1'b1;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) st_nxt = q_data.voice_ok ? ST_RD : ST_OUT;
      end
      ST_RD:  st_nxt = ST_MUL;
      ST_MUL: st_nxt = ST_Y;
      ST_Y:   st_nxt = ST_ACC;
      ST_ACC: st_nxt = last_blk ? ST_RND : ST_RD;
      ST_RND: st_nxt = ST_M0;
      ST_M0:  st_nxt = ST_M1;
      ST_M1:  st_nxt = ST_M2;
      ST_M2:  st_nxt = ST_M3;
      ST_M3:  st_nxt = ST_OUT;
      ST_OUT: begin
        if (res_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (st_r == ST_IDLE) && !q_empty;
    mem_we    = (st_r == ST_Y);
    res_valid = (st_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      vld_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (mem_we) vld_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[addr] <= x_cur;
      mem_y[addr] <= y_sat;
    end
    if (st_r == ST_RD) begin
      x1_r  <= mem_x[addr];
      y1_r  <= mem_y[addr];
      hit_r <= vld_r[addr];
    end
  end

  // Blocker arithmetic: y = (x - x1)*64 + round(coef*y1 / 2^30)
  always_comb begin
    unique case (k_r)
      BLK_CH1:  x_cur = cur_r.ch1;
      BLK_CH2:  x_cur = cur_r.ch2;
      BLK_CH3L: x_cur = cur_r.ch3_l;
      BLK_CH3R: x_cur = cur_r.ch3_r;
      BLK_CH4L: x_cur = cur_r.ch4_l;
      BLK_CH4R: x_cur = cur_r.ch4_r;
      default:  x_cur = cur_r.ch1;
    endcase
    x1_eff   = hit_r ? x1_r : '0;
    y1_eff   = hit_r ? y1_r : '0;
    prod_rnd = 64'(prod_r) + 64'sd536870912;
    y_sum    = 35'(xd_r <<< 6) + 35'(prod_rnd >>> 30);
    if (y_sum > 35'sd2147483647)       y_sat = 32'sh7FFFFFFF;
    else if (y_sum < -35'sd2147483648) y_sat = 32'sh80000000;
    else                               y_sat = y_sum[STATE_W-1:0];
  end

  always_comb begin
    g_l   = gains.ch1_l;
    g_r   = gains.ch1_r;
    add_l = 1'b1;
    add_r = 1'b1;
    unique case (k_r)
      BLK_CH1: begin
        g_l = gains.ch1_l;
        g_r = gains.ch1_r;
      end
      BLK_CH2: begin
        g_l = gains.ch2_l;
        g_r = gains.ch2_r;
      end
      BLK_CH3L: begin
        g_l   = gains.ch3;
        g_r   = gains.ch3;
        add_r = !cur_r.ch3_r_present;
      end
      BLK_CH3R: begin
        g_l   = gains.ch3;
        g_r   = gains.ch3;
        add_l = 1'b0;
      end
      BLK_CH4L: begin
        g_l   = gains.ch4;
        g_r   = gains.ch4;
        add_r = !cur_r.ch4_r_present;
      end
      BLK_CH4R: begin
        g_l   = gains.ch4;
        g_r   = gains.ch4;
        add_l = 1'b0;
      end
      default: begin
        add_l = 1'b0;
        add_r = 1'b0;
      end
    endcase
  end

  // Post scaling: one multiplier shared by the three outputs
  always_comb begin
    acc_l_rnd = 54'(acc_l_r) + 54'sd32768;
    acc_r_rnd = 54'(acc_r_r) + 54'sd32768;
    hsum      = 40'(l24_r) + 40'(r24_r);
    m_a       = 40'(l24_r);
    m_g       = gains.main;
    unique case (st_r)
      ST_M1: begin
        m_a = 40'(r24_r);
        m_g = gains.main;
      end
      ST_M2: begin
        m_a = hsum;
        m_g = gains.hp;
      end
      default: begin
        m_a = 40'(l24_r);
        m_g = gains.main;
      end
    endcase
    p_rnd = 60'(p_r) + 60'sd2097152;
    p_sh  = 38'(p_rnd >>> 22);
    if (p_sh > 38'(OUT_LIMIT))       p_sat = OUT_LIMIT;
    else if (p_sh < -38'(OUT_LIMIT)) p_sat = -OUT_LIMIT;
    else                             p_sat = p_sh[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        cur_r   <= q_data;
        k_r     <= BLK_CH1;
        acc_l_r <= '0;
        acc_r_r <= '0;
        ml_r    <= '0;
        mr_r    <= '0;
        hp_r    <= '0;
      end
      ST_MUL: begin
        prod_r <= 63'(y1_eff * 32'sd1 * DC_COEF);
        xd_r   <= 25'(x_cur) - 25'(x1_eff);
      end
      ST_Y: y_r <= y_sat;
      ST_ACC: begin
        if (add_l) acc_l_r <= acc_l_r + 53'(y_r * $signed({1'b0, g_l}));
        if (add_r) acc_r_r <= acc_r_r + 53'(y_r * $signed({1'b0, g_r}));
        k_r <= k_nxt;
      end
      ST_RND: begin
        l24_r <= 39'(acc_l_rnd >>> 16) <<< 1;
        r24_r <= 39'(acc_r_rnd >>> 16) <<< 1;
      end
      ST_M0: p_r <= 59'(m_a * $signed({1'b0, m_g}));
      ST_M1: begin
        ml_r <= p_sat;
        p_r  <= 59'(m_a * $signed({1'b0, m_g}));
      end
      ST_M2: begin
        mr_r <= p_sat;
        p_r  <= 59'(m_a * $signed({1'b0, m_g}));
      end
      ST_M3: hp_r <= p_sat;
      default: ;
    endcase
  end

  always_comb begin
    res.voice      = cur_r.voice;
    res.main_left  = ml_r;
    res.main_right = mr_r;
    res.headphone  = hp_r;
  end

`ifndef SYNTH
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == ST_RD || st_r == ST_OUT))
    else $error("popped request did not start");
  a_bad_voice_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !cur_r.voice_ok) |->
      (res.main_left == 0 && res.main_right == 0 && res.headphone == 0))
    else $error("out-of-range voice gave nonzero output");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("blocker state not cleared by reset");
  a_last_blk: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ACC && k_r == BLK_CH4R) |=> (st_r == ST_RND))
    else $error("blocker sequence ran past the last slot");
`endif

endmodule

// ===== hw/rtl/poly_dc_blocked_stereo_mixer.sv =====
// ----------------------------------------------------------------------------
// poly_dc_blocked_stereo_mixer
// Four-channel stereo mixer with per-voice DC blockers and gain registers.
// ----------------------------------------------------------------------------
// Port group | Direction | Content
// in_*       | input     | one voice: six samples, right-present flags
// out_*      | output    | voice, main left/right, headphone
// cfg_*      | APB       | eight gain registers at byte address 4*i
//
// A request runs read, coefficient multiply, sum and gain multiply-accumulate
// for each DC blocker it uses, then rounding, the post-scaling multiplies and
// the output state; an out-of-range voice goes straight to output. The blocker
// state memory has one read/write port.
// Reset clears blocker state through per-entry valid bits; gains reset to 1.0.
// A two-entry queue decouples input from the sequencer; the output register
// holds a result while the next request is worked on.
module poly_dc_blocked_stereo_mixer #(
  parameter int unsigned NUM_VOICES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // voice[3:0], ch1[27:4], ch2[51:28], ch3_left[75:52], ch3_right[99:76],
  // ch4_left[123:100], ch4_right[147:124], zero pad
  input  logic [151:0] in_tdata,
  // ch3_right_present[0], ch4_right_present[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_voice[3:0], main_left[26:4], main_right[49:27], headphone[72:50], pad
  output logic [79:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import psm_pkg::*;

  gains_t   gains_r;
  reg_idx_t widx;
  logic     cfg_we;
  logic [GAIN_W-1:0] rd_gain;

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_in, q_out;
  logic  res_valid, res_ready;
  res_t  res;
  logic  out_valid_r;
  res_t  out_r;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx       = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= {8{18'd65536}};
    end else if (cfg_we) begin
      unique case (widx)
        REG_CH1_L: gains_r.ch1_l <= cfg_pwdata[GAIN_W-1:0];
        REG_CH1_R: gains_r.ch1_r <= cfg_pwdata[GAIN_W-1:0];
        REG_CH2_L: gains_r.ch2_l <= cfg_pwdata[GAIN_W-1:0];
        REG_CH2_R: gains_r.ch2_r <= cfg_pwdata[GAIN_W-1:0];
        REG_CH3:   gains_r.ch3   <= cfg_pwdata[GAIN_W-1:0];
        REG_CH4:   gains_r.ch4   <= cfg_pwdata[GAIN_W-1:0];
        REG_HP:    gains_r.hp    <= cfg_pwdata[GAIN_W-1:0];
        REG_MAIN:  gains_r.main  <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_CH1_L: rd_gain = gains_r.ch1_l;
      REG_CH1_R: rd_gain = gains_r.ch1_r;
      REG_CH2_L: rd_gain = gains_r.ch2_l;
      REG_CH2_R: rd_gain = gains_r.ch2_r;
      REG_CH3:   rd_gain = gains_r.ch3;
      REG_CH4:   rd_gain = gains_r.ch4;
      REG_HP:    rd_gain = gains_r.hp;
      REG_MAIN:  rd_gain = gains_r.main;
      default:   rd_gain = '0;
    endcase
    cfg_prdata = {14'd0, rd_gain};
  end

  psm_front #(.NUM_VOICES(NUM_VOICES)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  psm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  psm_back #(.NUM_VOICES(NUM_VOICES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gains     (gains_r),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Hold the result until taken; refill in the same cycle it leaves
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.headphone, out_r.main_right, out_r.main_left,
                       out_r.voice};

endmodule

// ===== tb/poly_dc_blocked_stereo_mixer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// poly_dc_blocked_stereo_mixer_tb
// Streams voice requests through the mixer under changing gain settings and
// stall patterns, and checks every result against an in-bench predictor of
// the DC blockers, mixing, rounding and saturation.
// ----------------------------------------------------------------------------
module poly_dc_blocked_stereo_mixer_tb;
  import psm_pkg::*;

  localparam int NVOICE    = 16;
  localparam int WDOG_MAX  = 4000;
  localparam longint LIM   = 2883584;
  localparam longint COEF  = 1073204953;

  typedef struct {
    logic [3:0]         voice;
    logic signed [23:0] smp [6];
    logic [1:0]         rpres;
  } voice_req_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  poly_dc_blocked_stereo_mixer #(.NUM_VOICES(NVOICE)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [17:0] gain [8];
  longint      blk_x [NVOICE*6];
  longint      blk_y [NVOICE*6];

  voice_req_t  pending_reqs [$];
  logic [72:0] expected_mix [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          n_err = 0;
  int          wdog = 0;
  int          n_sent = 0;
  bit          timed_out = 0;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint dc_step(int idx, longint x);
    longint y;
    y = (x - blk_x[idx]) * 64 + rnd_shift(blk_y[idx] * COEF, 30);
    y = clip(y, -64'sd2147483648, 64'sd2147483647);
    blk_x[idx] = x;
    blk_y[idx] = y;
    return y;
  endfunction

  function automatic logic [72:0] mix_voice(voice_req_t r);
    longint y1, y2, y3l, y3r, y4l, y4r, sl, sr, l24, r24, ml, mr, hp;
    int b;
    if (r.voice >= NVOICE) return {69'd0, r.voice};
    b = r.voice * 6;
    y1 = dc_step(b + BLK_CH1, r.smp[0]);
    y2 = dc_step(b + BLK_CH2, r.smp[1]);
    y3l = dc_step(b + BLK_CH3L, r.smp[2]);
    y4l = dc_step(b + BLK_CH4L, r.smp[4]);
    y3r = r.rpres[0] ? dc_step(b + BLK_CH3R, r.smp[3]) : y3l;
    y4r = r.rpres[1] ? dc_step(b + BLK_CH4R, r.smp[5]) : y4l;
    sl = y1 * gain[REG_CH1_L] + y2 * gain[REG_CH2_L] + y3l * gain[REG_CH3]
       + y4l * gain[REG_CH4];
    sr = y1 * gain[REG_CH1_R] + y2 * gain[REG_CH2_R] + y3r * gain[REG_CH3]
       + y4r * gain[REG_CH4];
    l24 = rnd_shift(sl, 16) * 2;
    r24 = rnd_shift(sr, 16) * 2;
    ml = clip(rnd_shift(l24 * gain[REG_MAIN], 22), -LIM, LIM);
    mr = clip(rnd_shift(r24 * gain[REG_MAIN], 22), -LIM, LIM);
    hp = clip(rnd_shift((l24 + r24) * gain[REG_HP], 22), -LIM, LIM);
    return {hp[22:0], mr[22:0], ml[22:0], r.voice};
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          voice_req_t r;
          r = pending_reqs.pop_front();
          in_tdata <= {4'd0, r.smp[5], r.smp[4], r.smp[3], r.smp[2], r.smp[1],
                       r.smp[0], r.voice};
          in_tuser <= r.rpres;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // predict on accepted request, check on accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        voice_req_t r;
        r.voice = in_tdata[3:0];
        for (int k = 0; k < 6; k++) r.smp[k] = in_tdata[4 + 24*k +: 24];
        r.rpres = in_tuser;
        expected_mix.push_back(mix_voice(r));
        n_sent++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_mix.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h", out_tdata[72:0]);
        end else begin
          logic [72:0] e;
          e = expected_mix.pop_front();
          if (e !== out_tdata[72:0]) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: voice exp %0d got %0d | ml exp %0d got %0d | "
                       , e[3:0], out_tdata[3:0], $signed(e[26:4]),
                       $signed(out_tdata[26:4]),
                       "mr exp %0d got %0d | hp exp %0d got %0d",
                       $signed(e[49:27]), $signed(out_tdata[49:27]),
                       $signed(e[72:50]), $signed(out_tdata[72:50]));
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (pending_reqs.size() == 0 && expected_mix.size() == 0 && !in_tvalid))
        wdog <= 0;
      else
        wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_gain(reg_idx_t idx, logic [17:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {14'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    gain[idx] = val;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return $signed(24'($urandom_range(2000))) - 24'sd1000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic add_req(logic [3:0] v, logic [1:0] p);
    voice_req_t r;
    r.voice = v;
    r.rpres = p;
    for (int k = 0; k < 6; k++) r.smp[k] = rand_sample();
    pending_reqs.push_back(r);
  endtask

  // wait until all queued requests are out, then let the sequencer settle
  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_mix.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    voice_req_t r;
    for (int i = 0; i < 8; i++) gain[i] = 18'd65536;
    for (int i = 0; i < NVOICE*6; i++) begin
      blk_x[i] = 0;
      blk_y[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, both present flags, every voice
    for (int s = 0; s < 2; s++) begin
      r.voice = 4'd0; r.rpres = 2'b11;
      for (int k = 0; k < 6; k++) r.smp[k] = s ? 24'sh800000 : 24'sh7FFFFF;
      pending_reqs.push_back(r);
    end
    r.voice = 4'd15; r.rpres = 2'b00;
    for (int k = 0; k < 6; k++) r.smp[k] = '0;
    pending_reqs.push_back(r);
    for (int v = 0; v < 16; v++) add_req(4'(v), v[1:0]);
    for (int k = 0; k < 4; k++) add_req(4'd3, 2'(k));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: for (int i = 0; i < 8; i++) write_gain(reg_idx_t'(i), 18'd0);
        1: for (int i = 0; i < 8; i++) write_gain(reg_idx_t'(i), 18'h3FFFF);
        2: for (int i = 0; i < 8; i++) write_gain(reg_idx_t'(i), 18'd131072);
        default:
          for (int i = 0; i < 8; i++) write_gain(reg_idx_t'(i), 18'($urandom_range(131072)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int i = 0; i < 65; i++) add_req(4'($urandom), 2'($urandom));
      drain();
    end

    if (n_err == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
